[src/tetra_plane_split_defines.svh]
// Assertion macros for the plane split block
`ifndef TETRA_PLANE_SPLIT_DEFINES_SVH
`define TETRA_PLANE_SPLIT_DEFINES_SVH
// assert a property on the block clock, ignored in reset
`define TPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition that must never be seen on the block clock, ignored in reset
`define TPS_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`endif

[src/tps_pkg.sv]
// Shared types and constants for the plane split block
package tps_pkg;
    localparam int NORM_BITS = 18;
    localparam int OFFS_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int THETA_BITS = 17;
    localparam logic [THETA_BITS-1:0] THETA_ONE = 17'h10000;

    typedef enum logic [2:0] {
        CFG_NX = 3'd0,
        CFG_NY = 3'd1,
        CFG_NZ = 3'd2,
        CFG_OFFS = 3'd3,
        CFG_FIRST = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_NEG = 2'd1,
        KIND_POS = 2'd2
    } t_kind;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

[src/tps_divider.sv]
// Restoring divider for the edge parameter, one quotient bit per cycle
module tps_divider #(
    parameter int W = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output tps_pkg::t_div_ctl o_ctl,
    output logic [15:0] o_quot
);
    import tps_pkg::*;

    logic [W:0] r_rem, n_rem;
    logic [W-1:0] r_den;
    logic [15:0] r_quot;
    logic [4:0] r_cnt;
    logic r_busy, r_done;

    always_comb begin
        n_rem = {r_rem[W-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd16;
                r_rem <= {1'b0, i_num};
                r_den <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_den}) begin
                    r_rem <= n_rem - {1'b0, r_den};
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quot <= {r_quot[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
    assign o_quot = r_quot;
endmodule

[src/tetra_plane_split.sv]
// Top level: plane cut of one tetrahedron into crossing points and sub-tetrahedra
// Corners load under start while idle (slots 0 to 2). The slot 3 item runs a sequencer:
// four distances through one shared multiplier (high product, low product and accumulate
// step on each of three axes, then one store step per corner), one planning step, then
// per crossing point one setup step, the 16-bit divide when it is needed (it is skipped
// when the edge parameter is settled without dividing), and three interpolations and the
// point output, then one build step when points were made and each tetrahedron in turn.
// Results appear for one cycle under o_valid and cannot be stalled.
// Configuration is written through its own valid/ready channel, always ready.
`include "tetra_plane_split_defines.svh"
module tetra_plane_split #(
    parameter int INDEX_BITS = 24,
    parameter int COORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] i_corner_slot,
    input  logic [INDEX_BITS-1:0] i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_z,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic o_valid,
    output logic [1:0] o_item_kind,
    output logic [INDEX_BITS-1:0] o_corner_a,
    output logic [INDEX_BITS-1:0] o_corner_b,
    output logic [INDEX_BITS-1:0] o_corner_c,
    output logic [INDEX_BITS-1:0] o_corner_d,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS-1:0] o_point_z,
    output logic o_last_of_run
);
    import tps_pkg::*;

    localparam int PB = COORD_BITS + 24;   // phi width
    localparam int HB = COORD_BITS - FRAC_BITS;
    localparam int AB = NORM_BITS + 1;
    localparam int BB = HB + 2;
    localparam int MB = AB + BB;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PHI  = 7'b0000010,
        S_PLAN = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_WAIT = 7'b0010000,
        S_LERP = 7'b0100000,
        S_TET  = 7'b1000000
    } t_state;

    t_state r_state;
    logic signed [NORM_BITS-1:0] r_nx, r_ny, r_nz;
    logic signed [OFFS_BITS-1:0] r_offs;
    logic [INDEX_BITS-1:0] r_next;
    logic [INDEX_BITS-1:0] r_idx [4];
    logic signed [COORD_BITS-1:0] r_crd [4][3];
    logic signed [PB-1:0] r_phi [4];
    logic signed [PB-1:0] r_hi, r_lo;
    logic [1:0] r_ci;
    logic [2:0] r_step;
    logic [2:0] r_pn, r_np;
    logic [1:0] r_ea [4];
    logic [1:0] r_eb [4];
    logic [INDEX_BITS-1:0] r_pid [4];
    logic [3:0] r_tn, r_nt;
    logic [INDEX_BITS*4-1:0] r_tq [6];
    logic [1:0] r_tk [6];
    logic [THETA_BITS-1:0] r_theta;
    logic signed [COORD_BITS-1:0] r_pt [3];

    // shared multiplier
    logic signed [AB-1:0] m_a;
    logic signed [BB-1:0] m_b;
    logic signed [MB-1:0] m_p;
    logic signed [MB-1:0] r_prod;
    logic r_pv;
    logic [1:0] r_ax;

    t_div_ctl div_ctl;
    logic [15:0] div_q;
    logic div_go;
    logic [PB-1:0] div_num, div_den;
    logic signed [PB-1:0] pa, pb_, den;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    function automatic logic signed [AB-1:0] nsel(input logic [1:0] a,
        input logic signed [NORM_BITS-1:0] x, input logic signed [NORM_BITS-1:0] y,
        input logic signed [NORM_BITS-1:0] z);
        case (a)
            2'd0: nsel = AB'(x);
            2'd1: nsel = AB'(y);
            default: nsel = AB'(z);
        endcase
    endfunction

    logic signed [COORD_BITS-1:0] c_sel, c_sela, c_selb;
    logic signed [COORD_BITS:0] c_d;
    assign c_sel = r_crd[r_ci][r_ax];
    assign c_sela = r_crd[r_ea[r_pn[1:0]]][r_ax];
    assign c_selb = r_crd[r_eb[r_pn[1:0]]][r_ax];
    assign c_d = {c_selb[COORD_BITS-1], c_selb} - {c_sela[COORD_BITS-1], c_sela};

    // phi pass: axes one after another, product in two halves of the coordinate; else theta times edge delta
    always_comb begin
        if (r_state == S_PHI) begin
            m_a = nsel(r_ax, r_nx, r_ny, r_nz);
            m_b = r_step[0] ? BB'({1'b0, c_sel[FRAC_BITS-1:0]})
                            : BB'(c_sel >>> FRAC_BITS);
        end else begin
            m_a = AB'($signed({1'b0, r_theta}));
            m_b = r_step[0] ? BB'({1'b0, c_d[FRAC_BITS-1:0]})
                            : BB'(c_d >>> FRAC_BITS);
        end
        m_p = MB'(m_a) * MB'(m_b);
    end

    assign pa = r_phi[r_ea[r_pn[1:0]]];
    assign pb_ = r_phi[r_eb[r_pn[1:0]]];
    assign den = pa - pb_;
    assign div_num = pa < 0 ? PB'(-pa) : PB'(pa);
    assign div_den = den < 0 ? PB'(-den) : PB'(den);

    tps_divider #(.W(PB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_num(div_num), .i_den(div_den), .o_ctl(div_ctl), .o_quot(div_q)
    );

    // positive-corner plan
    logic [3:0] pos;
    logic [2:0] npos;
    logic [1:0] lone;
    logic [1:0] ng0, ng1, ps0, ps1;
    always_comb begin
        for (int i = 0; i < 4; i++) pos[i] = (r_phi[i] > 0);
        npos = 3'(pos[0]) + 3'(pos[1]) + 3'(pos[2]) + 3'(pos[3]);
        lone = 2'd0;
        for (int i = 3; i >= 0; i--)
            if (pos[i] == (npos == 3'd1)) lone = 2'(i);
        ng0 = 2'd0; ng1 = 2'd0; ps0 = 2'd0; ps1 = 2'd0;
        begin
            logic fn, fp;
            fn = 1'b0; fp = 1'b0;
            for (int i = 0; i < 4; i++) begin
                if (!pos[i]) begin
                    if (!fn) ng0 = 2'(i); else ng1 = 2'(i);
                    fn = 1'b1;
                end else begin
                    if (!fp) ps0 = 2'(i); else ps1 = 2'(i);
                    fp = 1'b1;
                end
            end
        end
    end

    logic signed [PB-1:0] phi_sum;
    assign phi_sum = r_hi + (r_lo >>> FRAC_BITS) - PB'(r_offs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nx <= '0; r_ny <= '0; r_nz <= NORM_BITS'(65536);
            r_offs <= '0;
            r_next <= '0;
            o_valid <= 1'b0;
            o_last_of_run <= 1'b0;
            div_go <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            o_last_of_run <= 1'b0;
            div_go <= 1'b0;
            r_pv <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NX: r_nx <= i_cfg_data[NORM_BITS-1:0];
                    CFG_NY: r_ny <= i_cfg_data[NORM_BITS-1:0];
                    CFG_NZ: r_nz <= i_cfg_data[NORM_BITS-1:0];
                    CFG_OFFS: r_offs <= i_cfg_data;
                    CFG_FIRST: r_next <= INDEX_BITS'(i_cfg_data);
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_idx[i_corner_slot] <= i_vertex_index;
                    r_crd[i_corner_slot][0] <= i_vertex_x;
                    r_crd[i_corner_slot][1] <= i_vertex_y;
                    r_crd[i_corner_slot][2] <= i_vertex_z;
                    if (i_corner_slot == 2'd3) begin
                        r_state <= S_PHI;
                        r_ci <= 2'd0; r_ax <= 2'd0; r_step <= '0;
                        r_hi <= '0; r_lo <= '0;
                    end
                end
                S_PHI: begin
                    // step0: hi product, step1: add hi and lo product, step2: add lo, step3: store
                    if (r_step == 3'd0) begin
                        r_prod <= m_p; r_step <= 3'd1;
                    end else if (r_step == 3'd1) begin
                        r_hi <= r_hi + PB'(r_prod);
                        r_prod <= m_p; r_step <= 3'd2;
                    end else if (r_step == 3'd2) begin
                        r_lo <= r_lo + PB'(r_prod);
                        r_step <= 3'd0;
                        if (r_ax == 2'd2) begin
                            r_ax <= 2'd0;
                            r_step <= 3'd3;
                        end else r_ax <= r_ax + 2'd1;
                    end
                    if (r_step == 3'd3) begin
                        r_phi[r_ci] <= phi_sum;
                        r_hi <= '0; r_lo <= '0; r_step <= 3'd0;
                        if (r_ci == 2'd3) r_state <= S_PLAN;
                        r_ci <= r_ci + 2'd1;
                    end
                end
                S_PLAN: begin
                    r_pn <= '0; r_tn <= '0;
                    if (npos == 3'd0 || npos == 3'd4) begin
                        r_np <= 3'd0; r_nt <= 4'd1;
                        r_tk[0] <= (npos == 3'd0) ? KIND_NEG : KIND_POS;
                        r_tq[0] <= {r_idx[0], r_idx[1], r_idx[2], r_idx[3]};
                        r_state <= S_TET;
                    end else if (npos == 3'd2) begin
                        r_np <= 3'd4; r_nt <= 4'd6;
                        r_ea[0] <= ng0; r_ea[1] <= ng0; r_ea[2] <= ng1; r_ea[3] <= ng1;
                        if (((ng1 - ng0) & 2'd1) == 2'd1) begin
                            r_eb[0] <= ps1; r_eb[1] <= ps0; r_eb[2] <= ps1; r_eb[3] <= ps0;
                        end else begin
                            r_eb[0] <= ps0; r_eb[1] <= ps1; r_eb[2] <= ps0; r_eb[3] <= ps1;
                        end
                        r_state <= S_DIV;
                    end else begin
                        r_np <= 3'd3; r_nt <= 4'd4;
                        for (int j = 0; j < 3; j++) begin
                            r_ea[j] <= lone;
                            r_eb[j] <= lone + 2'(j + 1);
                        end
                        r_ea[3] <= lone; r_eb[3] <= lone;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (den == 0) begin
                        r_theta <= THETA_ONE; r_state <= S_LERP;
                    end else if (pa == 0 || ((pa < 0) != (den < 0))) begin
                        r_theta <= '0; r_state <= S_LERP;
                    end else if (div_num >= div_den) begin
                        r_theta <= THETA_ONE; r_state <= S_LERP;
                    end else begin
                        div_go <= 1'b1; r_state <= S_WAIT;
                    end
                    r_ax <= 2'd0; r_step <= '0;
                end
                S_WAIT: if (div_ctl.done) begin
                    r_theta <= {1'b0, div_q}; r_state <= S_LERP;
                end
                S_LERP: begin
                    if (r_step == 3'd0) begin
                        r_prod <= m_p; r_step <= 3'd1;
                    end else if (r_step == 3'd1) begin
                        r_hi <= PB'(r_prod);
                        r_prod <= m_p; r_step <= 3'd2;
                    end else if (r_step == 3'd2) begin
                        r_pt[r_ax] <= COORD_BITS'(PB'(c_sela) + r_hi
                            + (PB'(r_prod) >>> FRAC_BITS));
                        r_step <= 3'd0;
                        if (r_ax == 2'd2) begin
                            r_ax <= 2'd0; r_step <= 3'd4;
                        end else r_ax <= r_ax + 2'd1;
                    end
                    if (r_step == 3'd4) begin
                        o_valid <= 1'b1;
                        o_item_kind <= KIND_POINT;
                        o_corner_a <= r_next;
                        o_corner_b <= '0; o_corner_c <= '0; o_corner_d <= '0;
                        o_point_x <= r_pt[0]; o_point_y <= r_pt[1]; o_point_z <= r_pt[2];
                        r_pid[r_pn[1:0]] <= r_next;
                        r_next <= r_next + INDEX_BITS'(1);
                        r_pn <= r_pn + 3'd1;
                        r_step <= '0;
                        r_state <= (r_pn + 3'd1 == r_np) ? S_TET : S_DIV;
                    end
                end
                S_TET: begin
                    if (r_tn == 4'd0 && r_np != 3'd0) begin
                        // build quadruples from the created point indices
                        if (r_np == 3'd3) begin
                            logic [INDEX_BITS-1:0] p0, p1, p2, o0, o1, o2, li;
                            logic [1:0] kl, kr;
                            li = r_idx[r_ea[0]];
                            p1 = r_pid[1]; o1 = r_idx[r_eb[1]];
                            if (r_ea[0][0] == 1'b0) begin
                                p0 = r_pid[2]; p2 = r_pid[0];
                                o0 = r_idx[r_eb[2]]; o2 = r_idx[r_eb[0]];
                            end else begin
                                p0 = r_pid[0]; p2 = r_pid[2];
                                o0 = r_idx[r_eb[0]]; o2 = r_idx[r_eb[2]];
                            end
                            kl = pos[r_ea[0]] ? KIND_POS : KIND_NEG;
                            kr = pos[r_ea[0]] ? KIND_NEG : KIND_POS;
                            r_tk[0] <= kl; r_tq[0] <= {li, p0, p1, p2};
                            r_tk[1] <= kr; r_tq[1] <= {p0, o0, o1, o2};
                            r_tk[2] <= kr; r_tq[2] <= {p1, p0, o1, o2};
                            r_tk[3] <= kr; r_tq[3] <= {p2, p0, p1, o2};
                        end else begin
                            logic [INDEX_BITS-1:0] n0, n1, q0, q1, c00, c01, c10, c11;
                            n0 = r_idx[r_ea[0]]; n1 = r_idx[r_ea[2]];
                            q0 = r_idx[r_eb[0]]; q1 = r_idx[r_eb[1]];
                            c00 = r_pid[0]; c01 = r_pid[1]; c10 = r_pid[2]; c11 = r_pid[3];
                            r_tk[0] <= KIND_NEG; r_tq[0] <= {n0, c10, n1, c11};
                            r_tk[1] <= KIND_NEG; r_tq[1] <= {n0, c10, c11, c01};
                            r_tk[2] <= KIND_NEG; r_tq[2] <= {n0, c00, c10, c01};
                            r_tk[3] <= KIND_POS; r_tq[3] <= {q0, c01, q1, c11};
                            r_tk[4] <= KIND_POS; r_tq[4] <= {q0, c01, c11, c10};
                            r_tk[5] <= KIND_POS; r_tq[5] <= {q0, c00, c01, c10};
                        end
                        r_np <= 3'd0;
                    end else begin
                        o_valid <= 1'b1;
                        o_item_kind <= r_tk[r_tn[2:0]];
                        {o_corner_a, o_corner_b, o_corner_c, o_corner_d} <= r_tq[r_tn[2:0]];
                        o_point_x <= '0; o_point_y <= '0; o_point_z <= '0;
                        r_tn <= r_tn + 4'd1;
                        if (r_tn + 4'd1 == r_nt) begin
                            o_last_of_run <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TPS_ASSERT(a_last_valid, o_last_of_run |-> o_valid, "last without valid")
    `TPS_ASSERT(a_idle_after_last, o_last_of_run |-> !busy, "busy after last")
    `TPS_ASSERT(a_div_busy, div_ctl.busy |-> r_state == S_WAIT, "divider outside wait")
    `TPS_NEVER(a_done_outside_wait, div_ctl.done && r_state != S_WAIT, "done outside wait")
endmodule
